/* src/min_priority_queue_macros.svh */
// ----------------------------------------------------------------------------
// min_priority_queue_macros
// Assertion macros shared by the queue checker.
// ----------------------------------------------------------------------------
`ifndef MIN_PRIORITY_QUEUE_MACROS_SVH
`define MIN_PRIORITY_QUEUE_MACROS_SVH

// clocked assertion, disabled while reset is held
`define MPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked implication, disabled while reset is held
`define MPQ_ASSERT_IMP(lbl, ante, cons, msg) \
  `MPQ_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

/* src/mpq_pkg.sv */
// ----------------------------------------------------------------------------
// mpq_pkg
// Shared types and constants of the min priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package mpq_pkg;

  // number of cells in the chain, one key each
  localparam int CAPACITY = 64;
  localparam int KEY_W    = 32;
  localparam int OCC_W    = 7;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic {
    MODE_INSERT = 1'b0,
    MODE_REMOVE = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // operation broadcast to every cell
  typedef struct packed {
    logic                    ins;
    logic                    rem;
    logic signed [KEY_W-1:0] key;
  } cell_op_t;

  // what a cell shows its neighbors
  typedef struct packed {
    logic                    vld;
    logic                    lt;
    logic signed [KEY_W-1:0] key;
  } cell_link_t;

  // boundary seen by the first cell on its left
  localparam cell_link_t HEAD_LINK = '{vld: 1'b1, lt: 1'b0, key: '0};
  // boundary seen by the last cell on its right
  localparam cell_link_t TAIL_LINK = '{vld: 1'b0, lt: 1'b1, key: '0};

endpackage

`default_nettype wire

/* src/mpq_cell.sv */
// ----------------------------------------------------------------------------
// mpq_cell
// One slot of the sorted chain: holds a key and shifts with its neighbors.
// ----------------------------------------------------------------------------
`default_nettype none

module mpq_cell
  import mpq_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cell_op_t   op,
  input  wire cell_link_t left_i,
  input  wire cell_link_t right_i,
  output cell_link_t      link_o
);

  logic                    vld_r, vld_nxt;
  logic signed [KEY_W-1:0] key_r, key_nxt;
  logic                    lt;

  // new key belongs at or before this slot
  assign lt = !vld_r || (op.key < key_r);

  // insert shifts right from the insertion point, remove shifts left
  always_comb begin
    vld_nxt = vld_r;
    key_nxt = key_r;
    if (op.ins) begin
      if (lt) begin
        key_nxt = left_i.lt ? left_i.key : op.key;
        vld_nxt = vld_r | left_i.vld;
      end
    end else if (op.rem) begin
      key_nxt = right_i.key;
      vld_nxt = right_i.vld;
    end
  end

  // occupancy flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // key payload
  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  assign link_o = '{vld: vld_r, lt: lt, key: key_r};

endmodule

`default_nettype wire

/* src/min_priority_queue.sv */
// ----------------------------------------------------------------------------
// min_priority_queue
// Bounded min-priority queue of signed 32-bit keys built as a sorted chain
// of CAPACITY cells, smallest key in the first cell. An insert compares the
// key against every cell at once and the cells past the insertion point
// shift one place right; a remove takes the first cell's key and the whole
// chain shifts one place left. Each transfer updates the whole chain at once
// and its result appears on the output in the cycle after acceptance; the input takes
// one item per cycle as long as results are taken, since the single output
// register is the only stall point. The rate is set by the chain-wide
// compare and shift, which is combinational ahead of the cell registers.
// ----------------------------------------------------------------------------
`default_nettype none

module min_priority_queue
  import mpq_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_mode,
  input  wire logic signed [31:0] in_key,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [1:0]             out_status,
  output logic signed [31:0]     out_min_key,
  output logic [OCC_W-1:0]       out_occupancy
);

  cell_link_t links [CAPACITY];
  cell_op_t   op;

  logic             in_xfer;
  logic             is_ins, is_rem;
  logic             full, empty;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r;
  status_t          status_r, status_nxt;
  logic signed [KEY_W-1:0] min_key_r, min_key_nxt;
  logic [OCC_W-1:0] occ_r;

  // input handshake, blocked only while a result waits
  assign in_ready = !out_valid_r || out_ready;
  assign in_xfer  = in_valid && in_ready;
  assign is_ins   = in_xfer && (mode_t'(in_mode) == MODE_INSERT);
  assign is_rem   = in_xfer && (mode_t'(in_mode) == MODE_REMOVE);

  assign full  = links[CAPACITY-1].vld;
  assign empty = !links[0].vld;

  // operation for the chain
  assign op = '{ins: is_ins && !full, rem: is_rem && !empty, key: in_key};

  // cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_link_t left_l, right_l;
    if (i == 0) begin : g_head
      assign left_l = HEAD_LINK;
    end else begin : g_left
      assign left_l = links[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_l = TAIL_LINK;
    end else begin : g_right
      assign right_l = links[i+1];
    end
    mpq_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .op      (op),
      .left_i  (left_l),
      .right_i (right_l),
      .link_o  (links[i])
    );
  end

  // key count
  always_comb begin
    priority if (op.ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (op.rem) begin
      count_nxt = count_r - CNT_W'(1);
    end else begin
      count_nxt = count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // result of the accepted item
  always_comb begin
    status_nxt  = ST_OK;
    min_key_nxt = '0;
    if (is_ins && full) begin
      status_nxt = ST_FULL;
    end else if (is_rem && empty) begin
      status_nxt = ST_EMPTY;
    end else if (is_rem) begin
      min_key_nxt = links[0].key;
    end
  end

  // output register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      status_r  <= status_nxt;
      min_key_r <= min_key_nxt;
      occ_r     <= OCC_W'(count_nxt);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = status_r;
  assign out_min_key   = min_key_r;
  assign out_occupancy = occ_r;

endmodule

`default_nettype wire

/* src/mpq_checker.sv */
// ----------------------------------------------------------------------------
// mpq_checker
// Port-level checks of the min priority queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "min_priority_queue_macros.svh"

module mpq_checker
  import mpq_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              in_mode,
  input wire logic signed [31:0] in_key,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [1:0]        out_status,
  input wire logic signed [31:0] out_min_key,
  input wire logic [OCC_W-1:0]  out_occupancy
);

  logic        in_wait, out_wait;
  logic [32:0] in_payload;
  logic [40:0] out_payload;
  logic        res_full, res_empty;
  logic        occ_full, occ_zero, no_key;

  // stalled transfers and their payloads
  assign in_wait     = in_valid && !in_ready;
  assign out_wait    = out_valid && !out_ready;
  assign in_payload  = {in_mode, in_key};
  assign out_payload = {out_status, out_min_key, out_occupancy};

  // refused-item result fields
  assign res_full  = out_valid && (out_status == ST_FULL);
  assign res_empty = out_valid && (out_status == ST_EMPTY);
  assign occ_full  = (out_occupancy == OCC_W'(CAPACITY));
  assign occ_zero  = (out_occupancy == '0);
  assign no_key    = (out_min_key == '0);

  // a waiting input item stays with its payload
  `MPQ_ASSERT_IMP(a_in_hold, in_wait, ##1 (in_valid && $stable(in_payload)), "input item changed")

  // a waiting result stays
  `MPQ_ASSERT_IMP(a_out_hold, out_wait, ##1 out_valid, "result dropped")

  // a waiting result keeps its payload
  `MPQ_ASSERT_IMP(a_out_stable, out_wait, ##1 $stable(out_payload), "result payload changed")

  // a refused insert leaves a full queue and no key
  `MPQ_ASSERT_IMP(a_full, res_full, occ_full && no_key, "full result inconsistent")

  // a refused remove leaves an empty queue and no key
  `MPQ_ASSERT_IMP(a_empty, res_empty, occ_zero && no_key, "empty result inconsistent")

endmodule

bind min_priority_queue mpq_checker u_mpq_checker (.*);

`default_nettype wire

/* bench/min_priority_queue_tb.sv */
// ----------------------------------------------------------------------------
// min_priority_queue_tb
// Self-checking bench for the bounded min priority queue. Directed tests hit
// removes from an empty queue, extreme and repeated keys, and inserts into a
// full queue. Random traffic then sweeps the occupancy between empty and
// full under three sender/receiver idling mixes. A local queue model predicts
// every reply, and each result transfer is checked field by field in order.
// ----------------------------------------------------------------------------

module min_priority_queue_tb;
  import mpq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD  = 10;
  localparam int CYCLE_LIMIT = 400_000;
  localparam int TAIL_CYCLES = 8;

  // one predicted reply
  typedef struct {
    status_t                 status;
    logic signed [KEY_W-1:0] min_key;
    logic [OCC_W-1:0]        occupancy;
  } queue_reply_t;

  logic                    clk       = 1'b0;
  logic                    rst_n     = 1'b0;
  logic                    in_valid  = 1'b0;
  logic                    in_ready;
  logic                    in_mode   = MODE_INSERT;
  logic signed [31:0]      in_key    = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [1:0]              out_status;
  logic signed [31:0]      out_min_key;
  logic [OCC_W-1:0]        out_occupancy;

  // queue model state
  logic signed [KEY_W-1:0] held_keys [CAPACITY];
  int                      held_count = 0;
  queue_reply_t            expected_replies [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int fail_count     = 0;
  int cycle_count    = 0;

  min_priority_queue i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_mode       (in_mode),
    .in_key        (in_key),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_min_key   (out_min_key),
    .out_occupancy (out_occupancy)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // run time guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    out_ready <= rst_n && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // apply one accepted operation to the model and queue its reply
  function automatic void predict_queue_op(input mode_t op,
                                           input logic signed [KEY_W-1:0] key_val);
    queue_reply_t reply;
    int           best;
    reply.status  = ST_OK;
    reply.min_key = '0;
    if (op == MODE_INSERT) begin
      if (held_count >= CAPACITY) begin
        reply.status = ST_FULL;
      end else begin
        held_keys[held_count] = key_val;
        held_count++;
      end
    end else if (held_count == 0) begin
      reply.status = ST_EMPTY;
    end else begin
      best = 0;
      for (int i = 1; i < held_count; i++) begin
        if (held_keys[i] < held_keys[best]) best = i;
      end
      reply.min_key = held_keys[best];
      held_count--;
      held_keys[best] = held_keys[held_count];
    end
    reply.occupancy = OCC_W'(held_count);
    expected_replies.push_back(reply);
  endfunction

  // watch both channels: predict on input transfer, check on result transfer
  always @(posedge clk) begin : reply_check
    queue_reply_t want;
    if (rst_n) begin
      if (in_valid && in_ready) predict_queue_op(mode_t'(in_mode), in_key);
      if (out_valid && out_ready) begin
        if (expected_replies.size() == 0) begin
          $error("result transfer with no reply pending");
          fail_count++;
        end else begin
          want = expected_replies.pop_front();
          if (out_status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_status);
            fail_count++;
          end
          if (out_min_key !== want.min_key) begin
            $error("min_key: expected %0d, actual %0d", want.min_key, out_min_key);
            fail_count++;
          end
          if (out_occupancy !== want.occupancy) begin
            $error("occupancy: expected %0d, actual %0d", want.occupancy, out_occupancy);
            fail_count++;
          end
        end
      end
    end
  end

  // key mix: full range, a narrow band for repeats, and the extremes
  function automatic logic signed [31:0] random_key();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return $urandom;
      5, 6:          return $signed($urandom_range(0, 16)) - 8;
      7:             return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      8:             return 32'sh7FFF_FFFF - $signed($urandom_range(0, 3));
      default:       return 32'sh8000_0000 + $signed($urandom_range(0, 3));
    endcase
  endfunction

  // one input transfer, entered and left at a falling edge
  task automatic send_item(input mode_t op, input logic signed [31:0] key_val);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_mode  <= op;
    in_key   <= key_val;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // sender goes quiet until every reply has come back
  task automatic wait_for_replies();
    in_valid <= 1'b0;
    do @(negedge clk); while (expected_replies.size() != 0);
  endtask

  // removes with nothing held
  task automatic test_empty_remove();
    send_item(MODE_REMOVE, 32'sh7FFF_FFFF);
    send_item(MODE_REMOVE, -32'sd1);
  endtask

  // extreme, repeated and alternating keys, then drain past empty
  task automatic test_key_extremes();
    logic signed [31:0] keys [10];
    keys = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0, -32'sd1, 32'sd1,
             32'sd5, 32'sd5, -32'sd5, 32'sh5555_5555, 32'shAAAA_AAAA};
    foreach (keys[i]) send_item(MODE_INSERT, keys[i]);
    for (int i = 0; i < 11; i++) send_item(MODE_REMOVE, keys[i % 10]);
  endtask

  // fill to capacity, refused inserts, partial drain and refill, full drain, one remove past empty
  task automatic test_full_queue();
    while (held_count < CAPACITY) send_item(MODE_INSERT, random_key());
    send_item(MODE_INSERT, 32'sh8000_0000);
    send_item(MODE_INSERT, 32'sh7FFF_FFFF);
    send_item(MODE_INSERT, $urandom);
    for (int i = 0; i < 5; i++) send_item(MODE_REMOVE, $urandom);
    while (held_count < CAPACITY) send_item(MODE_INSERT, random_key());
    send_item(MODE_INSERT, -32'sd1);
    while (held_count > 0) send_item(MODE_REMOVE, $urandom);
    send_item(MODE_REMOVE, $urandom);
  endtask

  // sender holds off mid-stream until the queue has answered everything
  task automatic test_drain_pause();
    for (int i = 0; i < 20; i++) send_item(MODE_INSERT, random_key());
    wait_for_replies();
    for (int i = 0; i < 10; i++) send_item(MODE_REMOVE, $urandom);
  endtask

  // random walk of the occupancy, insert bias redrawn per segment
  task automatic test_random_traffic(input int n_items, input int idle_pct,
                                     input int stall_pct);
    int sent;
    int seg_left;
    int insert_pct;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent           = 0;
    seg_left       = 0;
    insert_pct     = 50;
    while (sent < n_items) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(8, 90);
        case ($urandom_range(0, 3))
          0:       insert_pct = 15;
          1:       insert_pct = 50;
          2:       insert_pct = 75;
          default: insert_pct = 95;
        endcase
      end
      if ($urandom_range(0, 99) < insert_pct) send_item(MODE_INSERT, random_key());
      else send_item(MODE_REMOVE, $urandom);
      sent++;
      seg_left--;
    end
  endtask

  initial begin
    // synchronous reset
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle_pct  = 32;
    recv_stall_pct = 78;
    test_empty_remove();
    test_key_extremes();
    test_full_queue();
    test_random_traffic(555, 32, 78);
    test_drain_pause();
    test_random_traffic(555, 78, 32);
    test_random_traffic(544, 0, 0);

    // let the last replies drain
    wait_for_replies();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
